>>> rtl/qte_pkg.sv
// Shared types, constants and helpers for the quaternion to Euler angle converter.
// No dependencies; every other file in rtl/ but qte_checker.sv refers to it by scoped names.
package qte_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANG_FRAC        = 30;
  localparam int VEC_W           = 64;
  localparam int Z_W             = 34;
  localparam int WIDE_W          = 36;
  localparam int ISQ_W           = 61;
  localparam int ISQ_CELLS       = 31;
  localparam int NORM_CELLS      = 6;
  localparam int THR_W           = 29;
  localparam int S30_SHIFT       = ANG_FRAC - 2 * QUAT_FRAC_BITS;
  localparam int OUT_SHIFT       = ANG_FRAC - ANGLE_FRAC_BITS;

  localparam logic [THR_W-1:0]        THR_RESET   = 29'd134190840;
  localparam logic signed [Z_W-1:0]   PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WIDE_W-1:0] ONE_Q      = 36'sd1 <<< (2 * QUAT_FRAC_BITS);

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic                    zero;
  } cvec_t;

  typedef struct packed {
    logic [ISQ_W-1:0] v;
    logic [ISQ_W-1:0] r;
  } isq_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] hy;
    logic signed [WIDE_W-1:0] hx;
    logic signed [WIDE_W-1:0] ay;
    logic signed [WIDE_W-1:0] ax;
    logic signed [31:0]       s30;
    pole_t                    code;
  } side_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 30'd843314856;
      5'd1:  return 30'd497837829;
      5'd2:  return 30'd263043836;
      5'd3:  return 30'd133525158;
      5'd4:  return 30'd67021686;
      5'd5:  return 30'd33543515;
      5'd6:  return 30'd16775850;
      5'd7:  return 30'd8388437;
      5'd8:  return 30'd4194282;
      5'd9:  return 30'd2097149;
      5'd10: return 30'd1048575;
      5'd11: return 30'd524287;
      5'd12: return 30'd262143;
      5'd13: return 30'd131071;
      5'd14: return 30'd65535;
      5'd15: return 30'd32767;
      5'd16: return 30'd16383;
      5'd17: return 30'd8191;
      5'd18: return 30'd4095;
      5'd19: return 30'd2047;
      5'd20: return 30'd1023;
      5'd21: return 30'd511;
      5'd22: return 30'd255;
      5'd23: return 30'd127;
      5'd24: return 30'd63;
      5'd25: return 30'd31;
      5'd26: return 30'd15;
      5'd27: return 30'd7;
      5'd28: return 30'd3;
      5'd29: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

  function automatic logic signed [WIDE_W-1:0] clamp(input logic signed [WIDE_W-1:0] v,
                                                     input logic signed [WIDE_W-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // round half up from Q.30 to the output fraction
  function automatic logic signed [WIDE_W-1:0] to_out(input logic signed [WIDE_W-1:0] z);
    return (z + (36'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
  endfunction

endpackage

>>> rtl/qte_isqrt_cell.sv
// One digit step of the integer square root chain.
// Depends on qte_pkg (isq_t).
module qte_isqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::isq_t   din,
  output qte_pkg::isq_t   dout
);

  localparam logic [qte_pkg::ISQ_W-1:0] ONE_BIT = 1;
  localparam logic [qte_pkg::ISQ_W-1:0] BIT     = ONE_BIT << BIT_POS;

  logic [qte_pkg::ISQ_W-1:0] rb;
  qte_pkg::isq_t             dout_next;

  always_comb begin
    rb = din.r + BIT;
    if (din.v >= rb) begin
      dout_next.v = din.v - rb;
      dout_next.r = (din.r >> 1) + BIT;
    end else begin
      dout_next.v = din.v;
      dout_next.r = din.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/qte_norm_cell.sv
// One step of the power-of-two normalizing shifter ahead of the CORDIC chain.
// Depends on qte_pkg (cvec_t).
module qte_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::cvec_t  din,
  output qte_pkg::cvec_t  dout
);

  logic [qte_pkg::VEC_W-1:0] mx;
  logic [qte_pkg::VEC_W-1:0] my;
  logic [qte_pkg::VEC_W-1:0] m;
  qte_pkg::cvec_t            dout_next;

  always_comb begin
    mx = din.x[qte_pkg::VEC_W-1] ? -din.x : din.x;
    my = din.y[qte_pkg::VEC_W-1] ? -din.y : din.y;
    m  = mx | my;
    dout_next = din;
    if ((m >> (60 - SHIFT)) == '0) begin
      dout_next.x = din.x <<< SHIFT;
      dout_next.y = din.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/qte_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain.
// Depends on qte_pkg (cvec_t, atan_q30).
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::cvec_t  din,
  output qte_pkg::cvec_t  dout
);

  logic signed [qte_pkg::VEC_W-1:0] xs;
  logic signed [qte_pkg::VEC_W-1:0] ys;
  logic signed [qte_pkg::Z_W-1:0]   ang;
  qte_pkg::cvec_t                   dout_next;

  always_comb begin
    xs  = din.x >>> IDX;
    ys  = din.y >>> IDX;
    ang = $signed({4'b0, qte_pkg::atan_q30(5'(IDX))});
    dout_next = din;
    if (!din.y[qte_pkg::VEC_W-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + ang;
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/qte_cordic.sv
// Pipelined atan2: normalizing shifter, quadrant fold and a row of CORDIC cells.
// Depends on qte_pkg, qte_norm_cell and qte_cordic_cell.
module qte_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::VEC_W-1:0]  x_in,
  input  logic signed [qte_pkg::VEC_W-1:0]  y_in,
  output logic signed [qte_pkg::Z_W-1:0]    z_out
);

  qte_pkg::cvec_t nv [0:qte_pkg::NORM_CELLS];
  qte_pkg::cvec_t cv [0:CORDIC_STEPS];
  qte_pkg::cvec_t quad_next;

  always_comb begin
    nv[0].x    = x_in;
    nv[0].y    = y_in;
    nv[0].z    = '0;
    nv[0].zero = (x_in == '0) && (y_in == '0);
  end

  for (genvar k = 0; k < qte_pkg::NORM_CELLS; k++) begin : g_norm
    qte_norm_cell #(.SHIFT(32 >> k)) u_norm (
      .clk (clk),
      .en  (en),
      .din (nv[k]),
      .dout(nv[k+1])
    );
  end

  always_comb begin
    quad_next = nv[qte_pkg::NORM_CELLS];
    if (nv[qte_pkg::NORM_CELLS].x[qte_pkg::VEC_W-1]) begin
      if (!nv[qte_pkg::NORM_CELLS].y[qte_pkg::VEC_W-1]) begin
        quad_next.x = nv[qte_pkg::NORM_CELLS].y;
        quad_next.y = -nv[qte_pkg::NORM_CELLS].x;
        quad_next.z = qte_pkg::HALF_PI_Q30;
      end else begin
        quad_next.x = -nv[qte_pkg::NORM_CELLS].y;
        quad_next.y = nv[qte_pkg::NORM_CELLS].x;
        quad_next.z = -qte_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv[0] <= quad_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    qte_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .din (cv[i]),
      .dout(cv[i+1])
    );
  end

  assign z_out = cv[CORDIC_STEPS].zero ? '0 : cv[CORDIC_STEPS].z;

endmodule

>>> rtl/quaternion_to_euler.sv
// Quaternion to Euler angles: one transaction in, one transaction out.
// Stages: products, pole test, radicand, isqrt cells, CORDIC atan2s, output register.
// Throughput: one quaternion per cycle; the whole pipe advances whenever the output
// register is empty or taken, so a held output stalls every stage together.
// Reset (rst, synchronous) clears the valid chain and loads pole_threshold with 0.4999.
// Depends on qte_pkg, qte_isqrt_cell and qte_cordic.
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [28:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  quat_w,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  bank_angle,
  output logic signed [16:0]  heading_angle,
  output logic signed [15:0]  attitude_angle,
  output logic [1:0]          pole_code
);

  localparam int CL   = qte_pkg::NORM_CELLS + 1 + CORDIC_STEPS;
  localparam int PIPE = 3 + qte_pkg::ISQ_CELLS + CL;
  localparam int NI   = qte_pkg::ISQ_CELLS;
  localparam int WW   = qte_pkg::WIDE_W;

  logic                          adv;
  logic [PIPE-1:0]               vld;
  logic [qte_pkg::THR_W-1:0]     pole_threshold;

  logic signed [31:0] p_xy, p_zw, p_yw, p_xz, p_yy, p_zz, p_xx, p_xw, p_yz;
  logic signed [15:0] t1_qx, t1_qw;

  qte_pkg::side_t     t2_side, t2_side_next;
  qte_pkg::side_t     t3_side;
  logic [qte_pkg::ISQ_W-1:0] t3_r;
  logic signed [63:0] sq;
  logic [qte_pkg::ISQ_W-1:0] t3_r_next;

  qte_pkg::side_t     sd [0:NI-1];
  qte_pkg::isq_t      iq [0:NI];
  qte_pkg::pole_t     cd [0:CL-1];

  logic signed [qte_pkg::Z_W-1:0] head_z, att_z, bank_z;

  logic signed [WW-1:0] test, thr, s, hy, hx, ay, ax;
  logic                 north, south;

  logic signed [WW-1:0] hz, az, bz, hsel, hout, aout, bout;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_threshold <= qte_pkg::THR_RESET;
    end else if (cfg_we) begin
      pole_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE-2:0], in_valid};
      out_valid <= vld[PIPE-1];
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xy  <= quat_x * quat_y;
      p_zw  <= quat_z * quat_w;
      p_yw  <= quat_y * quat_w;
      p_xz  <= quat_x * quat_z;
      p_yy  <= quat_y * quat_y;
      p_zz  <= quat_z * quat_z;
      p_xx  <= quat_x * quat_x;
      p_xw  <= quat_x * quat_w;
      p_yz  <= quat_y * quat_z;
      t1_qx <= quat_x;
      t1_qw <= quat_w;
    end
  end

  // pole test, clamped asin argument, atan2 operands
  always_comb begin
    test  = WW'(p_xy) + WW'(p_zw);
    thr   = $signed({{(WW - qte_pkg::THR_W){1'b0}}, pole_threshold});
    north = test > thr;
    south = test < -thr;
    s     = qte_pkg::clamp(test <<< 1, qte_pkg::ONE_Q);
    hy    = (WW'(p_yw) - WW'(p_xz)) <<< 1;
    hx    = qte_pkg::ONE_Q - ((WW'(p_yy) + WW'(p_zz)) <<< 1);
    ay    = (WW'(p_xw) - WW'(p_yz)) <<< 1;
    ax    = qte_pkg::ONE_Q - ((WW'(p_xx) + WW'(p_zz)) <<< 1);
    t2_side_next.s30 = 32'(s <<< qte_pkg::S30_SHIFT);
    t2_side_next.ax  = ax;
    t2_side_next.ay  = ay;
    if (north || south) begin
      t2_side_next.hy = WW'(t1_qx);
      t2_side_next.hx = WW'(t1_qw);
    end else begin
      t2_side_next.hy = hy;
      t2_side_next.hx = hx;
    end
    if (north) begin
      t2_side_next.code = qte_pkg::POLE_NORTH;
    end else if (south) begin
      t2_side_next.code = qte_pkg::POLE_SOUTH;
    end else begin
      t2_side_next.code = qte_pkg::POLE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_side <= t2_side_next;
    end
  end

  always_comb begin
    sq        = t2_side.s30 * t2_side.s30;
    t3_r_next = (qte_pkg::ISQ_W'(1) << 60) - sq[qte_pkg::ISQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_side <= t2_side;
      t3_r    <= t3_r_next;
    end
  end

  assign iq[0].v = t3_r;
  assign iq[0].r = '0;

  for (genvar k = 0; k < NI; k++) begin : g_isq
    qte_isqrt_cell #(.BIT_POS(2 * (NI - 1 - k))) u_isq (
      .clk (clk),
      .en  (adv),
      .din (iq[k]),
      .dout(iq[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= t3_side;
      for (int k = 1; k < NI; k++) begin
        sd[k] <= sd[k-1];
      end
      cd[0] <= sd[NI-1].code;
      for (int k = 1; k < CL; k++) begin
        cd[k] <= cd[k-1];
      end
    end
  end

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_head (
    .clk  (clk),
    .en   (adv),
    .x_in (qte_pkg::VEC_W'(sd[NI-1].hx)),
    .y_in (qte_pkg::VEC_W'(sd[NI-1].hy)),
    .z_out(head_z)
  );

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_att (
    .clk  (clk),
    .en   (adv),
    .x_in (qte_pkg::VEC_W'(sd[NI-1].ax)),
    .y_in (qte_pkg::VEC_W'(sd[NI-1].ay)),
    .z_out(att_z)
  );

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_bank (
    .clk  (clk),
    .en   (adv),
    .x_in ($signed({3'b0, iq[NI].r})),
    .y_in (qte_pkg::VEC_W'(sd[NI-1].s30)),
    .z_out(bank_z)
  );

  always_comb begin
    hz = qte_pkg::clamp(WW'(head_z), WW'(qte_pkg::PI_Q30));
    az = qte_pkg::clamp(WW'(att_z), WW'(qte_pkg::PI_Q30));
    bz = qte_pkg::clamp(WW'(bank_z), WW'(qte_pkg::HALF_PI_Q30));
    case (cd[CL-1])
      qte_pkg::POLE_NORTH: begin
        hsel = hz <<< 1;
        bout = qte_pkg::to_out(WW'(qte_pkg::HALF_PI_Q30));
        aout = '0;
      end
      qte_pkg::POLE_SOUTH: begin
        hsel = -(hz <<< 1);
        bout = qte_pkg::to_out(-WW'(qte_pkg::HALF_PI_Q30));
        aout = '0;
      end
      default: begin
        hsel = hz;
        bout = qte_pkg::to_out(bz);
        aout = qte_pkg::to_out(az);
      end
    endcase
    hout = qte_pkg::to_out(hsel);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bank_angle     <= bout[14:0];
      heading_angle  <= hout[16:0];
      attitude_angle <= aout[15:0];
      pole_code      <= cd[CL-1];
    end
  end

endmodule

>>> rtl/qte_checker.sv
// Port-level checks for quaternion_to_euler, attached by the bind below.
// Depends on the top level's port list only.
module qte_props (
  input logic                clk,
  input logic                rst,
  input logic                cfg_we,
  input logic [28:0]         cfg_wdata,
  input logic                in_valid,
  input logic                in_ready,
  input logic signed [15:0]  quat_w,
  input logic signed [15:0]  quat_x,
  input logic signed [15:0]  quat_y,
  input logic signed [15:0]  quat_z,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [14:0]  bank_angle,
  input logic signed [16:0]  heading_angle,
  input logic signed [15:0]  attitude_angle,
  input logic [1:0]          pole_code
);

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output held");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading_angle) && $stable(pole_code))
    else $error("held output changed");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pole_code != 2'd3)
    else $error("bad pole code");

  a_pole_attitude: assert property (@(posedge clk) disable iff (rst)
    out_valid && pole_code != 2'd0 |-> attitude_angle == 16'sd0)
    else $error("attitude nonzero at pole");

  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bank_angle <= 15'sd12868 && bank_angle >= -15'sd12868)
    else $error("bank out of range");

endmodule

bind quaternion_to_euler qte_props u_qte_props (.*);
